// File: rtl/core/numeric_literal_recognizer_unit_macros.svh
// Assertion macros for the numeric literal recognizer.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef NUMERIC_LITERAL_RECOGNIZER_UNIT_MACROS_SVH
`define NUMERIC_LITERAL_RECOGNIZER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define NLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nlr assertion failed");

// next-cycle implication, disabled during reset
`define NLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlr assertion failed");

`else

`define NLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/nlr_pkg.sv
// Package for the numeric literal recognizer: scan phases, character classes,
// the grammar step function and shared constants. No dependencies.
`timescale 1ns / 1ps

package nlr_pkg;

  localparam int CHAR_W    = 16;
  localparam int LIT_LEN_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HEX   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_FLOAT = 1'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 16'h0058;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_LO_E  = 16'h0065;
  localparam logic [CHAR_W-1:0] CH_UP_E  = 16'h0045;
  localparam logic [CHAR_W-1:0] CH_USCORE = 16'h005F;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 16'h0046;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 16'h007A;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_SIGN = 4'd1,
    PH_ZERO = 4'd2,
    PH_INT  = 4'd3,
    PH_ZX   = 4'd4,
    PH_HEX  = 4'd5,
    PH_FRAC = 4'd6,
    PH_EXP  = 4'd7,
    PH_EXPD = 4'd8,
    PH_STOP = 4'd14,
    PH_FAIL = 4'd15
  } phase_t;

  // result of one character step
  typedef struct packed {
    logic                 fire;
    logic                 accepted;
    logic [LIT_LEN_W-1:0] length;
  } step_res_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_F));
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_exp(input logic [CHAR_W-1:0] c);
    return (c == CH_LO_E) || (c == CH_UP_E);
  endfunction

  // a literal may end here without being rejected
  function automatic logic phase_complete(input phase_t ph);
    return !((ph == PH_SIGN) || (ph == PH_ZX));
  endfunction

  // grammar transition for a character inside a literal
  function automatic phase_t advance(input phase_t ph, input logic [CHAR_W-1:0] c,
                                     input logic hex_en, input logic flt_en);
    phase_t nx;
    nx = PH_FAIL;
    case (ph)
      PH_SIGN: begin
        if (c == CH_ZERO) nx = PH_ZERO;
        else if (is_digit(c)) nx = PH_INT;
        else nx = PH_FAIL;
      end
      PH_ZERO, PH_INT: begin
        if ((ph == PH_ZERO) && ((c == CH_LO_X) || (c == CH_UP_X))) begin
          nx = hex_en ? PH_ZX : PH_FAIL;
        end else if (is_digit(c)) begin
          nx = PH_INT;
        end else if (flt_en && (c == CH_DOT)) begin
          nx = PH_FRAC;
        end else if (flt_en && is_exp(c)) begin
          nx = PH_EXP;
        end else begin
          nx = PH_STOP;
        end
      end
      PH_ZX:   nx = (hex_en && is_hex(c)) ? PH_HEX : PH_FAIL;
      PH_HEX:  nx = is_hex(c) ? PH_HEX : PH_STOP;
      PH_FRAC: begin
        if (is_digit(c)) nx = PH_FRAC;
        else if (flt_en && is_exp(c)) nx = PH_EXP;
        else nx = PH_STOP;
      end
      PH_EXP:  nx = (is_sign(c) || is_digit(c)) ? PH_EXPD : PH_STOP;
      PH_EXPD: nx = is_digit(c) ? PH_EXPD : PH_STOP;
      default: nx = PH_FAIL;
    endcase
    return nx;
  endfunction

endpackage

// File: rtl/core/nlr_in_if.sv
// Character channel interface: valid/ready plus one character word.
// Depends on nlr_pkg.
`timescale 1ns / 1ps

interface nlr_in_if;
  import nlr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_present;
  logic              start_req;
  logic              end_of_line;

  modport source (output valid, output char_code, output char_present,
                  output start_req, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input char_present,
                  input start_req, input end_of_line, output ready);
endinterface

// File: rtl/core/nlr_out_if.sv
// Result channel interface: valid/ready plus accept flag and literal length.
// Depends on nlr_pkg.
`timescale 1ns / 1ps

interface nlr_out_if;
  import nlr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [LIT_LEN_W-1:0] literal_length;

  modport source (output valid, output accepted, output literal_length, input ready);
  modport sink   (input valid, input accepted, input literal_length, output ready);
endinterface

// File: rtl/core/nlr_classify.sv
// Combinational step of the literal scanner: next phase, next count and result.
// Depends on nlr_pkg.
`timescale 1ns / 1ps

module nlr_classify #(
  parameter int LENGTH_BITS = 16
) (
  input  nlr_pkg::phase_t             phase_i,
  input  logic [LENGTH_BITS-1:0]      count_i,
  input  logic [nlr_pkg::CHAR_W-1:0]  char_code,
  input  logic                        char_present,
  input  logic                        start_req,
  input  logic                        end_of_line,
  input  logic                        allow_hex,
  input  logic                        allow_float,
  output nlr_pkg::phase_t             phase_o,
  output logic [LENGTH_BITS-1:0]      count_o,
  output nlr_pkg::step_res_t          res_o
);
  import nlr_pkg::*;

  logic                   fire;
  logic                   acc;
  logic [LENGTH_BITS-1:0] len_src;
  logic [LIT_LEN_W-1:0]   len_sat;

  // one character through the grammar
  always_comb begin
    phase_t nx;
    phase_o = phase_i;
    count_o = count_i;
    fire    = 1'b0;
    acc     = 1'b0;
    len_src = count_i;
    nx      = PH_FAIL;
    if (start_req) begin
      phase_o = PH_IDLE;
      count_o = '0;
      if (!char_present) begin
        fire = 1'b1;
      end else begin
        if (is_sign(char_code)) phase_o = PH_SIGN;
        else if (char_code == CH_ZERO) phase_o = PH_ZERO;
        else if (is_digit(char_code)) phase_o = PH_INT;
        else fire = 1'b1;
        if (!fire) count_o = LENGTH_BITS'(1);
      end
    end else if (phase_i != PH_IDLE) begin
      if (!char_present) begin
        fire = 1'b1;
        acc  = phase_complete(phase_i);
      end else begin
        nx = advance(phase_i, char_code, allow_hex, allow_float);
        if (nx == PH_FAIL) begin
          fire = 1'b1;
        end else if (nx == PH_STOP) begin
          fire = 1'b1;
          acc  = !((char_code == CH_DOT) || (char_code == CH_USCORE) || is_alpha(char_code));
        end else begin
          phase_o = nx;
          if (!(&count_i)) count_o = count_i + LENGTH_BITS'(1);
        end
      end
    end
    // end of line closes a literal still open
    if (!fire && end_of_line && (phase_o != PH_IDLE)) begin
      fire    = 1'b1;
      acc     = phase_complete(phase_o);
      len_src = count_o;
    end
    if (fire) begin
      phase_o = PH_IDLE;
      count_o = '0;
    end
  end

  // clamp the count to the result width
  if (LENGTH_BITS > LIT_LEN_W) begin : g_wide
    assign len_sat = (|len_src[LENGTH_BITS-1:LIT_LEN_W]) ? '1 : len_src[LIT_LEN_W-1:0];
  end else begin : g_narrow
    assign len_sat = LIT_LEN_W'(len_src);
  end

  assign res_o.fire     = fire;
  assign res_o.accepted = acc;
  assign res_o.length   = acc ? len_sat : '0;

endmodule

// File: rtl/core/numeric_literal_recognizer_unit.sv
// Numeric literal recognizer, top level. Depends on nlr_pkg, nlr_in_if, nlr_out_if,
// nlr_classify and the assertion macro header.
// A deciding character goes through the input register, then the result register.
// Throughput: one character per cycle unless the result channel stalls.
// Reset (synchronous, active low) clears the pipeline, the scan state and sets
// allow_hex and allow_float to 1.
`timescale 1ns / 1ps
`include "numeric_literal_recognizer_unit_macros.svh"

module numeric_literal_recognizer_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nlr_in_if.sink                         in_if,
  nlr_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [nlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nlr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import nlr_pkg::*;

  logic                   allow_hex_r;
  logic                   allow_float_r;

  logic                   s1_v_r;
  logic [CHAR_W-1:0]      s1_code_r;
  logic                   s1_present_r;
  logic                   s1_start_r;
  logic                   s1_eol_r;

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [LENGTH_BITS-1:0] count_r;
  logic [LENGTH_BITS-1:0] count_nxt;
  step_res_t              res;

  logic                   out_v_r;
  logic                   out_acc_r;
  logic [LIT_LEN_W-1:0]   out_len_r;
  logic                   adv;

  // stage 2 moves whenever the result register can take a word
  assign adv         = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_hex_r   <= 1'b1;
      allow_float_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALLOW_HEX:   allow_hex_r   <= cfg_wdata[0];
        REG_ALLOW_FLOAT: allow_float_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_code_r    <= in_if.char_code;
      s1_present_r <= in_if.char_present;
      s1_start_r   <= in_if.start_req;
      s1_eol_r     <= in_if.end_of_line;
    end
  end

  // grammar step
  nlr_classify #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_classify (
    .phase_i      (phase_r),
    .count_i      (count_r),
    .char_code    (s1_code_r),
    .char_present (s1_present_r),
    .start_req    (s1_start_r),
    .end_of_line  (s1_eol_r),
    .allow_hex    (allow_hex_r),
    .allow_float  (allow_float_r),
    .phase_o      (phase_nxt),
    .count_o      (count_nxt),
    .res_o        (res)
  );

  // scan state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r && res.fire;
      if (s1_v_r) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && s1_v_r && res.fire) begin
      out_acc_r <= res.accepted;
      out_len_r <= res.length;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.accepted       = out_acc_r;
  assign out_if.literal_length = out_len_r;

  // checks
  `NLR_ASSERT_IMPL(a_reject_len_zero, clk, rst_n, out_v_r && !out_acc_r, out_len_r == '0)
  `NLR_ASSERT_IMPL(a_accept_len_nonzero, clk, rst_n, out_v_r && out_acc_r, out_len_r != '0)
  `NLR_ASSERT_NEXT(a_idle_after_result, clk, rst_n, s1_v_r && adv && res.fire, phase_r == PH_IDLE)
  `NLR_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_if.ready, s1_v_r && out_v_r && !out_if.ready)

endmodule

// File: tb/nlr_literal_checker.sv
// Checker for the numeric literal recognizer: follows the character and result
// channels and the register writes, predicts each result and compares it.
// Depends on nlr_pkg, nlr_in_if and nlr_out_if.
`timescale 1ns / 1ps

module nlr_literal_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  nlr_in_if                             in_ch,
  nlr_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [nlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nlr_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import nlr_pkg::*;

  typedef logic [CHAR_W-1:0] code_t;

  typedef struct packed {
    logic                 accepted;
    logic [LIT_LEN_W-1:0] literal_length;
  } literal_result_t;

  // mirrored registers and scan state
  logic                 hex_on = 1'b1;
  logic                 float_on = 1'b1;
  phase_t               lex_phase = PH_IDLE;
  logic [LIT_LEN_W-1:0] lex_count = '0;

  literal_result_t results_due[$];
  int              mismatches = 0;
  int              due_count = 0;

  assign fail_count = mismatches;
  assign pending    = due_count;

  // character classes
  function automatic logic digit_char(input code_t c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic letter_char(input code_t c);
    return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
  endfunction

  function automatic logic hexdig_char(input code_t c);
    return c inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]};
  endfunction

  function automatic logic sign_char(input code_t c);
    return c inside {CH_PLUS, CH_MINUS};
  endfunction

  function automatic logic exp_mark(input code_t c);
    return c inside {CH_LO_E, CH_UP_E};
  endfunction

  // sign alone and a bare 0x cannot end a literal
  function automatic logic can_end(input phase_t ph);
    return (ph != PH_SIGN) && (ph != PH_ZX);
  endfunction

  // grammar step for a character after the first one
  function automatic phase_t grammar_next(input phase_t ph, input code_t c);
    logic   is_d;
    logic   dot_ok;
    logic   exp_ok;
    phase_t nx;
    is_d   = digit_char(c);
    dot_ok = float_on && (c == CH_DOT);
    exp_ok = float_on && exp_mark(c);
    nx     = PH_FAIL;
    case (ph)
      PH_SIGN: begin
        if (c == CH_ZERO) nx = PH_ZERO;
        else if (is_d) nx = PH_INT;
      end
      PH_ZERO, PH_INT: begin
        if ((ph == PH_ZERO) && (c inside {CH_LO_X, CH_UP_X})) nx = hex_on ? PH_ZX : PH_FAIL;
        else if (is_d) nx = PH_INT;
        else if (dot_ok) nx = PH_FRAC;
        else if (exp_ok) nx = PH_EXP;
        else nx = PH_STOP;
      end
      PH_ZX: begin
        if (hex_on && hexdig_char(c)) nx = PH_HEX;
      end
      PH_HEX:  nx = hexdig_char(c) ? PH_HEX : PH_STOP;
      PH_FRAC: begin
        if (is_d) nx = PH_FRAC;
        else if (exp_ok) nx = PH_EXP;
        else nx = PH_STOP;
      end
      PH_EXP:  nx = (sign_char(c) || is_d) ? PH_EXPD : PH_STOP;
      PH_EXPD: nx = is_d ? PH_EXPD : PH_STOP;
      default: nx = PH_FAIL;
    endcase
    return nx;
  endfunction

  // advance the scan by one character word, report a result if one is due
  task automatic lex_char(input code_t c, input logic present, input logic start,
                          input logic eol, output logic fired, output literal_result_t res);
    phase_t nx;
    logic   decided;
    fired   = 1'b0;
    decided = 1'b0;
    res     = '0;
    if (start) begin
      lex_phase = PH_IDLE;
      lex_count = '0;
      if (!present) decided = 1'b1;
      else if (sign_char(c)) lex_phase = PH_SIGN;
      else if (c == CH_ZERO) lex_phase = PH_ZERO;
      else if (digit_char(c)) lex_phase = PH_INT;
      else decided = 1'b1;
      fired = decided;
      if (!decided) lex_count = LIT_LEN_W'(1);
    end else if (lex_phase == PH_IDLE) begin
      // stray character between literals
      decided = 1'b1;
    end else if (!present) begin
      fired        = 1'b1;
      decided      = 1'b1;
      res.accepted = can_end(lex_phase);
    end else begin
      nx = grammar_next(lex_phase, c);
      if (nx == PH_FAIL) begin
        fired   = 1'b1;
        decided = 1'b1;
      end else if (nx == PH_STOP) begin
        // terminator is not consumed; glued dot, underscore or letter rejects
        fired        = 1'b1;
        decided      = 1'b1;
        res.accepted = !((c == CH_DOT) || (c == CH_USCORE) || letter_char(c));
      end else begin
        lex_phase = nx;
        if (lex_count != '1) lex_count = lex_count + 1'b1;
      end
    end
    if (!decided && eol) begin
      fired        = 1'b1;
      res.accepted = can_end(lex_phase);
    end
    if (fired) begin
      if (res.accepted) res.literal_length = lex_count;
      lex_phase = PH_IDLE;
      lex_count = '0;
    end
  endtask

  // compare taken results, follow register writes, predict from taken characters
  always @(posedge clk) begin
    literal_result_t want;
    literal_result_t res;
    logic            fired;
    if (!rst_n) begin
      hex_on    = 1'b1;
      float_on  = 1'b1;
      lex_phase = PH_IDLE;
      lex_count = '0;
      results_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result word: accepted %0d literal_length %0d",
                 out_ch.accepted, out_ch.literal_length);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_ch.accepted);
            mismatches++;
          end
          if (out_ch.literal_length !== want.literal_length) begin
            $error("literal_length: expected %0d, got %0d",
                   want.literal_length, out_ch.literal_length);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALLOW_HEX:   hex_on = cfg_wdata[0];
          REG_ALLOW_FLOAT: float_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        lex_char(in_ch.char_code, in_ch.char_present, in_ch.start_req, in_ch.end_of_line,
                 fired, res);
        if (fired) results_due.push_back(res);
      end
    end
    due_count <= results_due.size();
  end

endmodule

// File: tb/tb_numeric_literal_recognizer_unit.sv
// Top of the numeric literal recognizer testbench: clock, reset, character
// stimulus, result back-pressure, register settings and the verdict.
// Depends on nlr_pkg, nlr_in_if, nlr_out_if, nlr_literal_checker and the block.
`timescale 1ns / 1ps

module tb_numeric_literal_recognizer_unit;
  import nlr_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          NUM_PHASES      = 5;
  localparam int          ITEMS_PER_PHASE = 380;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_CYCLES    = 6;
  // register settings per phase, bit p is phase p
  localparam logic [NUM_PHASES-1:0] HEX_MODES = 5'b10101;
  localparam logic [NUM_PHASES-1:0] FLT_MODES = 5'b11001;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_TILDE = 16'h007E;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int   fail_count;
  int   pending;

  // stimulus controls; gaps_on and hold_reqs are read by the result side
  bit   gaps_on = 1'b1;
  int   hold_reqs = 0;
  int   literal_items = 0;

  nlr_in_if  in_ch ();
  nlr_out_if out_ch ();

  numeric_literal_recognizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nlr_literal_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // random character pickers
  function automatic logic [CHAR_W-1:0] any_code();
    if ($urandom_range(1)) return CHAR_W'($urandom_range(16'hFFFF));
    return CHAR_W'($urandom_range(CH_TILDE, CH_SPACE));
  endfunction

  function automatic logic [CHAR_W-1:0] digit_code();
    return CHAR_W'($urandom_range(CH_NINE, CH_ZERO));
  endfunction

  function automatic logic [CHAR_W-1:0] hex_code();
    case ($urandom_range(2))
      0:       return digit_code();
      1:       return CHAR_W'($urandom_range(CH_UP_F, CH_UP_A));
      default: return CHAR_W'($urandom_range(CH_LO_F, CH_LO_A));
    endcase
  endfunction

  // drive one character word and wait until it is taken
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic present,
                           input logic start, input logic eol);
    while (gaps_on && ($urandom_range(99) < 6)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= code;
    in_ch.char_present <= present;
    in_ch.start_req    <= start;
    in_ch.end_of_line  <= eol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // a whole ascii string, start on the first character
  task automatic send_text(input string text, input logic eol_last);
    for (int i = 0; i < text.len(); i++)
      send_char({8'h00, text[i]}, 1'b1, i == 0, eol_last && (i == text.len() - 1));
  endtask

  // well-formed literal with random content, sometimes broken, random terminator
  task automatic send_literal();
    logic [CHAR_W-1:0] lit[$];
    int                term;
    if ($urandom_range(1)) lit.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
    if ($urandom_range(9) < 3) begin
      lit.push_back(CH_ZERO);
      lit.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
      repeat ($urandom_range(5)) lit.push_back(hex_code());
    end else begin
      repeat ($urandom_range(1, 5)) lit.push_back(digit_code());
      if ($urandom_range(1)) begin
        lit.push_back(CH_DOT);
        repeat ($urandom_range(3)) lit.push_back(digit_code());
      end
      if ($urandom_range(1)) begin
        lit.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
        if ($urandom_range(1)) lit.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(3)) lit.push_back(digit_code());
      end
    end
    if ($urandom_range(9) == 0) lit[$urandom_range(lit.size() - 1)] = any_code();
    term = $urandom_range(5);
    foreach (lit[i]) send_char(lit[i], 1'b1, i == 0, (term == 0) && (i == lit.size() - 1));
    literal_items += lit.size() + 1;
    case (term)
      1: send_char(any_code(), 1'b0, 1'b0, 1'($urandom_range(1)));
      2: send_char(CH_SPACE, 1'b1, 1'b0, 1'($urandom_range(1)));
      3: begin
        case ($urandom_range(3))
          0:       send_char(CH_DOT, 1'b1, 1'b0, 1'($urandom_range(1)));
          1:       send_char(CH_USCORE, 1'b1, 1'b0, 1'($urandom_range(1)));
          2:       send_char(CHAR_W'($urandom_range(CH_UP_Z, CH_UP_A)), 1'b1, 1'b0, 1'b0);
          default: send_char(CHAR_W'($urandom_range(CH_LO_Z, CH_LO_A)), 1'b1, 1'b0, 1'b0);
        endcase
      end
      4: send_char(any_code(), 1'b1, 1'b0, 1'($urandom_range(1)));
      default: ;
    endcase
  endtask

  // random words with random flags
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_char(any_code(), $urandom_range(99) < 75, $urandom_range(99) < 30,
                $urandom_range(99) < 20);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_modes(input logic hex_en, input logic flt_en);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALLOW_HEX;
    cfg_wdata <= hex_en;
    @(negedge clk);
    cfg_index <= REG_ALLOW_FLOAT;
    cfg_wdata <= flt_en;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stalls plus requested long hold-offs
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left    = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ((hold_left == 0) && (holds_done != hold_reqs)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && ($urandom_range(99) < 6));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.char_present = 1'b0;
    in_ch.start_req    = 1'b0;
    in_ch.end_of_line  = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_ALLOW_HEX;
    cfg_wdata          = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cases under the reset settings
    send_char('0, 1'b0, 1'b1, 1'b0);           // start with no character
    send_char(16'hFFFF, 1'b1, 1'b1, 1'b1);     // bad first character, top code
    send_text("-", 1'b1);                      // sign alone at end of line
    send_text("+0X1f", 1'b0);
    send_char(16'hFFFF, 1'b0 + 1'b1, 1'b0, 1'b0);  // non-letter code ends the hex form
    send_text("7", 1'b0);
    send_text("9", 1'b1);                      // restart abandons the 7
    send_char({8'h00, "q"}, 1'b1, 1'b0, 1'b0); // stray character while idle
    send_text("1.5E+3", 1'b1);
    send_text("0xg", 1'b0);                    // 0x without a hex digit
    send_text("4a", 1'b0);                     // letter glued to the literal

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) set_modes(HEX_MODES[p], FLT_MODES[p]);
      gaps_on = (p != 1);
      literal_items = 0;
      while (literal_items < ITEMS_PER_PHASE) begin
        if ((p == 0) && (hold_reqs == 0) && (literal_items >= 100)) hold_reqs++;
        if ($urandom_range(99) < 15) send_noise();
        else send_literal();
      end
      // abandons any open literal, leaves the scanner idle
      send_char('0, 1'b0, 1'b1, 1'b0);
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
